// ===== design/bmpc_pkg.sv =====
// Package for the button multi-press counter.
// Holds the status codes, configuration register indexes, reset values and
// the configuration struct. No dependencies.
package bmpc_pkg;

    localparam int MaxPressesDefault = 7;

    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 16;
    localparam int TimeW    = 32;
    localparam int CountW   = 8;
    localparam int LimitW   = 16;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_SUCCESS = 2'd1,
        ST_FAILED  = 2'd2
    } t_status;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_ACTIVE_LOW  = 2'd0,
        CFG_DEBOUNCE_MS = 2'd1,
        CFG_TIMEOUT_MS  = 2'd2
    } t_cfg_idx;

    localparam logic              ActiveLowReset  = 1'b1;
    localparam logic [LimitW-1:0] DebounceMsReset = 16'd50;
    localparam logic [LimitW-1:0] TimeoutMsReset  = 16'd1000;

    typedef struct packed {
        logic              active_low;
        logic [LimitW-1:0] debounce_ms;
        logic [LimitW-1:0] timeout_ms;
    } t_cfg;

endpackage

// ===== design/bmpc_cfg.sv =====
// Configuration registers of the button multi-press counter.
// Decodes the plain write port into the t_cfg struct; depends on bmpc_pkg.
module bmpc_cfg
    import bmpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_ACTIVE_LOW:  n_cfg.active_low  = i_cfg_data[0];
                CFG_DEBOUNCE_MS: n_cfg.debounce_ms = i_cfg_data[LimitW-1:0];
                CFG_TIMEOUT_MS:  n_cfg.timeout_ms  = i_cfg_data[LimitW-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low  <= ActiveLowReset;
            r_cfg.debounce_ms <= DebounceMsReset;
            r_cfg.timeout_ms  <= TimeoutMsReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/bmpc_core.sv =====
// Press counting state and its one-pass update for the multi-press counter.
// Holds the level, timer starts, count and finished flag; depends on bmpc_pkg.
module bmpc_core
    import bmpc_pkg::*;
#(
    parameter int MAX_PRESSES = MaxPressesDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_cfg              i_cfg,
    input  logic              i_pin_level,
    input  logic [TimeW-1:0]  i_now_ms,
    output t_status           o_status,
    output logic [CountW-1:0] o_push_total
);

    localparam logic [CountW-1:0] MaxCount = CountW'(MAX_PRESSES);

    logic              r_prev_level;
    logic [TimeW-1:0]  r_deb_start;
    logic [TimeW-1:0]  r_tmo_start;
    logic [CountW-1:0] r_count;
    logic              r_done;

    logic              n_prev_level;
    logic [TimeW-1:0]  n_deb_start;
    logic [TimeW-1:0]  n_tmo_start;
    logic [CountW-1:0] n_count;
    logic              n_done;

    logic              active;
    logic              press_edge;
    logic              deb_ok;
    logic              counted;
    logic [CountW-1:0] count_upd;
    logic [TimeW-1:0]  tmo_start_upd;
    logic              expired;
    logic              done_upd;

    always_comb begin
        active        = ~i_cfg.active_low;
        press_edge    = (i_pin_level == active) && (r_prev_level != active);
        deb_ok        = (i_now_ms - r_deb_start) >= TimeW'(i_cfg.debounce_ms);
        counted       = press_edge && deb_ok;
        count_upd     = counted ? r_count + CountW'(1) : r_count;
        tmo_start_upd = counted ? i_now_ms : r_tmo_start;
        expired       = (i_now_ms - tmo_start_upd) >= TimeW'(i_cfg.timeout_ms);
        done_upd      = r_done | expired;
    end

    always_comb begin
        n_prev_level = i_pin_level;
        n_deb_start  = counted ? i_now_ms : r_deb_start;
        n_tmo_start  = expired ? i_now_ms : tmo_start_upd;
        n_count      = count_upd;
        n_done       = done_upd;
        o_status     = ST_BUSY;
        o_push_total = '0;
        if (count_upd > MaxCount) begin
            // Overflow: the finished flag stays for a later poll.
            n_count  = '0;
            o_status = ST_FAILED;
        end else if (done_upd) begin
            if (count_upd != '0) begin
                o_status     = ST_SUCCESS;
                o_push_total = count_upd;
            end else begin
                o_status = ST_FAILED;
            end
            n_count = '0;
            n_done  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_deb_start  <= '0;
            r_tmo_start  <= '0;
            r_count      <= '0;
            r_done       <= 1'b0;
        end else if (i_fire) begin
            r_prev_level <= n_prev_level;
            r_deb_start  <= n_deb_start;
            r_tmo_start  <= n_tmo_start;
            r_count      <= n_count;
            r_done       <= n_done;
        end
    end

endmodule

// ===== design/button_multi_press_counter.sv =====
// Button multi-press counter: each accepted poll word passes through the input
// register and then the result register; throughput one word per cycle while
// the result channel does not stall. Each poll is processed by the counting
// logic and written to the result register; the state update is one pass.
// Synchronous active-low reset clears the valid flags and counting state and
// loads the default configuration (active low, 50 ms debounce, 1000 ms timeout).
module button_multi_press_counter
    import bmpc_pkg::*;
#(
    parameter int MAX_PRESSES = MaxPressesDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_wr_en,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_data,
    // Poll input channel.
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_pin_level,
    input  logic [TimeW-1:0]    i_now_ms,
    // Result channel.
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [CountW-1:0]   o_push_total
);

    t_cfg cfg;

    // Input register: one poll word waiting for the counting logic.
    logic             r_in_valid;
    logic             r_in_level;
    logic [TimeW-1:0] r_in_now;

    // Result register.
    logic              r_out_valid;
    t_status           r_out_status;
    logic [CountW-1:0] r_out_total;

    t_status           step_status;
    logic [CountW-1:0] step_total;
    logic              out_ready;
    logic              fire;

    // The result register can take a new word when it is empty or drains now.
    assign out_ready = !r_out_valid || !i_stall;
    // The held poll is processed, and the state updated, when it can move on.
    assign fire      = r_in_valid && out_ready;
    // The input side stalls only when the held poll cannot move forward.
    assign o_stall   = r_in_valid && !out_ready;

    bmpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bmpc_core #(
        .MAX_PRESSES (MAX_PRESSES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_cfg        (cfg),
        .i_pin_level  (r_in_level),
        .i_now_ms     (r_in_now),
        .o_status     (step_status),
        .o_push_total (step_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_level <= i_pin_level;
            r_in_now   <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_status <= step_status;
            r_out_total  <= step_total;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_push_total = r_out_total;

    // A held poll that can move forward shows up as a result next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_valid)
        else $error("processed poll did not produce a result word");

    // The input side stalls only behind a stalled, full result register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");

    // A success carries a count between one and the press limit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SUCCESS) |->
            (o_push_total != '0 && o_push_total <= CountW'(MAX_PRESSES)))
        else $error("success reported with an out-of-range count");

    // Busy and failed words carry a zero count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_SUCCESS) |-> (o_push_total == '0))
        else $error("non-success result with a nonzero count");

endmodule
